/* hw/rtl/xxh_pkg.sv */
// ----------------------------------------------------------------------------
// xxh_pkg
// constants, types and round helpers shared by the xxh64 streaming blocks
// ----------------------------------------------------------------------------
package xxh_pkg;

    localparam logic [63:0] P1 = 64'd11400714785074694791;
    localparam logic [63:0] P2 = 64'd14029467366897019727;
    localparam logic [63:0] P3 = 64'd1609587929392839161;
    localparam logic [63:0] P4 = 64'd9650029242287828579;
    localparam logic [63:0] P5 = 64'd2870177450012600261;

    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    // one classified item as it sits in the queue
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } item_t;

    function automatic logic [63:0] rol(input logic [63:0] v, input int n);
        rol = (v << n) | (v >> (64 - n));
    endfunction

endpackage

/* hw/rtl/xxh_front.sv */
// ----------------------------------------------------------------------------
// xxh_front
// input side: accepts items, clamps the byte count, queues them for the core
// ----------------------------------------------------------------------------
module xxh_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [63:0]         s_data_bytes,
    input  logic [3:0]          s_byte_count,
    input  logic                s_last,
    output logic                q_valid,
    input  logic                q_ready,
    output xxh_pkg::item_t      q_item
);

    xxh_pkg::item_t mem_reg [xxh_pkg::QDEPTH];
    logic [xxh_pkg::QAW-1:0] wp_reg, rp_reg;
    logic [xxh_pkg::QAW:0]   cnt_reg;
    logic push, pop;
    xxh_pkg::item_t in_item;

    assign s_ready = (cnt_reg != (xxh_pkg::QAW+1)'(xxh_pkg::QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_item  = mem_reg[rp_reg];

    always_comb begin
        in_item.data  = s_data_bytes;
        in_item.count = (s_byte_count > 4'd8) ? 4'd8 : s_byte_count;
        in_item.last  = s_last;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (xxh_pkg::QAW+1)'(push) - (xxh_pkg::QAW+1)'(pop);
        end
    end

endmodule

/* hw/rtl/xxh_core.sv */
// ----------------------------------------------------------------------------
// xxh_core
// back side: stripe buffer, lane rounds, finalize and avalanche sequencer
// ----------------------------------------------------------------------------
module xxh_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [63:0]         cfg_wr_data,
    input  logic                q_valid,
    output logic                q_ready,
    input  xxh_pkg::item_t      q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [63:0]         m_hash_value
);

    typedef enum logic [4:0] {
        S_IDLE, S_BYTE, S_LR_MUL, S_LR_ROT, S_LR_MUL2,
        S_CV_SUM, S_CV_MUL, S_CV_ROT, S_CV_MUL2, S_CV_XOR, S_CV_MUL3,
        S_ADD_LEN, S_W8_MUL, S_W8_ROT, S_W8_MUL2, S_W8_XOR, S_W8_MUL3,
        S_W4_XOR, S_W4_MUL2, S_B1_MUL, S_B1_XOR, S_B1_MUL2,
        S_AV1, S_AV2, S_AV3, S_AV4, S_OUT
    } state_t;

    state_t state_reg;
    logic [63:0] seed_reg;
    logic [63:0] acc_reg [4];
    logic [7:0]  buf_reg [32];
    logic [4:0]  bcnt_reg;
    logic [63:0] total_reg;
    logic [63:0] h_reg, t_reg;
    logic [1:0]  lane_reg;
    logic [4:0]  p_reg;
    logic [63:0] data_reg;
    logic [3:0]  left_reg;
    logic        last_reg;
    logic [63:0] out_reg;
    logic        oval_reg;
    logic [4:0]  rem;
    logic [63:0] w8, w4, lw;
    logic        mul_go, mul_done;
    logic [63:0] mul_a, mul_b;
    logic [1:0]  mph_reg;
    logic [63:0] mpr_reg;
    logic [31:0] mx, my;
    logic [63:0] mpp;

    assign q_ready      = (state_reg == S_IDLE) && !cfg_wr_en;
    assign m_valid      = oval_reg;
    assign m_hash_value = out_reg;
    assign rem          = bcnt_reg - p_reg;

    always_comb begin
        w8 = '0;
        w4 = '0;
        lw = '0;
        for (int i = 0; i < 8; i++) begin
            w8[8*i +: 8] = buf_reg[5'(p_reg + 5'(i))];
            lw[8*i +: 8] = buf_reg[{lane_reg, 3'(i)}];
        end
        for (int i = 0; i < 4; i++) begin
            w4[8*i +: 8] = buf_reg[5'(p_reg + 5'(i))];
        end
    end

    // operands of the shared multiplier, held while a multiply state waits
    always_comb begin
        mul_go = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_LR_MUL: begin
                mul_go = 1'b1; mul_a = lw; mul_b = xxh_pkg::P2;
            end
            S_LR_MUL2, S_CV_MUL2, S_W8_MUL2: begin
                mul_go = 1'b1; mul_a = t_reg; mul_b = xxh_pkg::P1;
            end
            S_CV_MUL: begin
                mul_go = 1'b1; mul_a = acc_reg[lane_reg]; mul_b = xxh_pkg::P2;
            end
            S_CV_MUL3, S_W8_MUL3, S_B1_MUL2: begin
                mul_go = 1'b1; mul_a = h_reg; mul_b = xxh_pkg::P1;
            end
            S_W8_MUL: begin
                if (rem >= 5'd8) begin
                    mul_go = 1'b1; mul_a = w8; mul_b = xxh_pkg::P2;
                end else if (rem >= 5'd4) begin
                    mul_go = 1'b1; mul_a = w4; mul_b = xxh_pkg::P1;
                end
            end
            S_W4_MUL2: begin
                mul_go = 1'b1; mul_a = h_reg; mul_b = xxh_pkg::P2;
            end
            S_B1_MUL: begin
                if (p_reg < bcnt_reg) begin
                    mul_go = 1'b1; mul_a = 64'(buf_reg[p_reg]); mul_b = xxh_pkg::P5;
                end
            end
            S_AV1: begin
                mul_go = 1'b1; mul_a = h_reg ^ (h_reg >> 33); mul_b = xxh_pkg::P2;
            end
            S_AV2: begin
                mul_go = 1'b1; mul_a = h_reg ^ (h_reg >> 29); mul_b = xxh_pkg::P3;
            end
            default: begin
                mul_go = 1'b0;
            end
        endcase
    end

    // low 64 bits of a 64x64 product from three 32x32 partial products
    always_comb begin
        case (mph_reg)
            2'd1: begin
                mx = mul_a[63:32];
                my = mul_b[31:0];
            end
            2'd2: begin
                mx = mul_a[31:0];
                my = mul_b[63:32];
            end
            default: begin
                mx = mul_a[31:0];
                my = mul_b[31:0];
            end
        endcase
    end

    assign mpp      = mx * my;
    assign mul_done = mul_go && (mph_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn || !mul_go) mph_reg <= '0;
        else mph_reg <= mph_reg + 2'd1;
        if (mul_go && (mph_reg == 2'd0)) begin
            mpr_reg <= mpp;
        end else if (mul_go && (mph_reg != 2'd3)) begin
            mpr_reg[63:32] <= mpr_reg[63:32] + mpp[31:0];
        end
        if (!aresetn) oval_reg <= 1'b0;
        else if ((state_reg == S_AV4) && (!oval_reg || m_ready)) oval_reg <= 1'b1;
        else if (m_ready) oval_reg <= 1'b0;
        if (!aresetn || cfg_wr_en) begin
            if (!aresetn) begin
                seed_reg <= '0;
                acc_reg[0] <= xxh_pkg::P1 + xxh_pkg::P2;
                acc_reg[1] <= xxh_pkg::P2;
                acc_reg[2] <= '0;
                acc_reg[3] <= -xxh_pkg::P1;
                state_reg <= S_IDLE;
            end else begin
                seed_reg <= cfg_wr_data;
                acc_reg[0] <= cfg_wr_data + xxh_pkg::P1 + xxh_pkg::P2;
                acc_reg[1] <= cfg_wr_data + xxh_pkg::P2;
                acc_reg[2] <= cfg_wr_data;
                acc_reg[3] <= cfg_wr_data - xxh_pkg::P1;
            end
            bcnt_reg  <= '0;
            total_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        data_reg  <= q_item.data;
                        left_reg  <= q_item.count;
                        last_reg  <= q_item.last;
                        total_reg <= total_reg + 64'(q_item.count);
                        state_reg <= S_BYTE;
                    end
                end
                S_BYTE: begin
                    if (left_reg != 4'd0) begin
                        buf_reg[bcnt_reg] <= data_reg[7:0];
                        data_reg <= data_reg >> 8;
                        left_reg <= left_reg - 4'd1;
                        bcnt_reg <= bcnt_reg + 5'd1;
                        if (bcnt_reg == 5'd31) begin
                            lane_reg  <= 2'd0;
                            state_reg <= S_LR_MUL;
                        end
                    end else if (last_reg) begin
                        if (total_reg >= 64'd32) begin
                            state_reg <= S_CV_SUM;
                        end else begin
                            h_reg     <= seed_reg + xxh_pkg::P5;
                            state_reg <= S_ADD_LEN;
                        end
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_LR_MUL: begin
                    if (mul_done) begin
                        t_reg <= acc_reg[lane_reg] + mpr_reg;
                        state_reg <= S_LR_ROT;
                    end
                end
                S_LR_ROT: begin
                    t_reg <= xxh_pkg::rol(t_reg, 31);
                    state_reg <= S_LR_MUL2;
                end
                S_LR_MUL2: begin
                    if (mul_done) begin
                        acc_reg[lane_reg] <= mpr_reg;
                        lane_reg <= lane_reg + 2'd1;
                        state_reg <= (lane_reg == 2'd3) ? S_BYTE : S_LR_MUL;
                    end
                end
                S_CV_SUM: begin
                    h_reg <= xxh_pkg::rol(acc_reg[0], 1) + xxh_pkg::rol(acc_reg[1], 7)
                           + xxh_pkg::rol(acc_reg[2], 12) + xxh_pkg::rol(acc_reg[3], 18);
                    lane_reg  <= 2'd0;
                    state_reg <= S_CV_MUL;
                end
                S_CV_MUL: begin
                    if (mul_done) begin
                        t_reg <= mpr_reg;
                        state_reg <= S_CV_ROT;
                    end
                end
                S_CV_ROT: begin
                    t_reg <= xxh_pkg::rol(t_reg, 31);
                    state_reg <= S_CV_MUL2;
                end
                S_CV_MUL2: begin
                    if (mul_done) begin
                        t_reg <= mpr_reg;
                        state_reg <= S_CV_XOR;
                    end
                end
                S_CV_XOR: begin
                    h_reg <= h_reg ^ t_reg;
                    state_reg <= S_CV_MUL3;
                end
                S_CV_MUL3: begin
                    if (mul_done) begin
                        h_reg <= mpr_reg + xxh_pkg::P4;
                        lane_reg <= lane_reg + 2'd1;
                        state_reg <= (lane_reg == 2'd3) ? S_ADD_LEN : S_CV_MUL;
                    end
                end
                S_ADD_LEN: begin
                    h_reg <= h_reg + total_reg;
                    p_reg <= '0;
                    state_reg <= S_W8_MUL;
                end
                S_W8_MUL: begin
                    if (rem >= 5'd8) begin
                        if (mul_done) begin
                            t_reg <= mpr_reg;
                            state_reg <= S_W8_ROT;
                        end
                    end else if (rem >= 5'd4) begin
                        if (mul_done) begin
                            t_reg <= mpr_reg;
                            state_reg <= S_W4_XOR;
                        end
                    end else begin
                        state_reg <= S_B1_MUL;
                    end
                end
                S_W8_ROT: begin
                    t_reg <= xxh_pkg::rol(t_reg, 31);
                    state_reg <= S_W8_MUL2;
                end
                S_W8_MUL2: begin
                    if (mul_done) begin
                        t_reg <= mpr_reg;
                        state_reg <= S_W8_XOR;
                    end
                end
                S_W8_XOR: begin
                    h_reg <= xxh_pkg::rol(h_reg ^ t_reg, 27);
                    state_reg <= S_W8_MUL3;
                end
                S_W8_MUL3: begin
                    if (mul_done) begin
                        h_reg <= mpr_reg + xxh_pkg::P4;
                        p_reg <= p_reg + 5'd8;
                        state_reg <= S_W8_MUL;
                    end
                end
                S_W4_XOR: begin
                    h_reg <= xxh_pkg::rol(h_reg ^ t_reg, 23);
                    state_reg <= S_W4_MUL2;
                end
                S_W4_MUL2: begin
                    if (mul_done) begin
                        h_reg <= mpr_reg + xxh_pkg::P3;
                        p_reg <= p_reg + 5'd4;
                        state_reg <= S_B1_MUL;
                    end
                end
                S_B1_MUL: begin
                    if (p_reg < bcnt_reg) begin
                        if (mul_done) begin
                            t_reg <= mpr_reg;
                            state_reg <= S_B1_XOR;
                        end
                    end else begin
                        state_reg <= S_AV1;
                    end
                end
                S_B1_XOR: begin
                    h_reg <= xxh_pkg::rol(h_reg ^ t_reg, 11);
                    state_reg <= S_B1_MUL2;
                end
                S_B1_MUL2: begin
                    if (mul_done) begin
                        h_reg <= mpr_reg;
                        p_reg <= p_reg + 5'd1;
                        state_reg <= S_B1_MUL;
                    end
                end
                S_AV1: begin
                    if (mul_done) begin
                        h_reg <= mpr_reg;
                        state_reg <= S_AV2;
                    end
                end
                S_AV2: begin
                    if (mul_done) begin
                        h_reg <= mpr_reg;
                        state_reg <= S_AV3;
                    end
                end
                S_AV3: begin
                    h_reg <= h_reg ^ (h_reg >> 32);
                    state_reg <= S_AV4;
                end
                S_AV4: begin
                    if (!oval_reg || m_ready) begin
                        out_reg  <= h_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    acc_reg[0] <= seed_reg + xxh_pkg::P1 + xxh_pkg::P2;
                    acc_reg[1] <= seed_reg + xxh_pkg::P2;
                    acc_reg[2] <= seed_reg;
                    acc_reg[3] <= seed_reg - xxh_pkg::P1;
                    bcnt_reg  <= '0;
                    total_reg <= '0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/xxh64_streaming_hash_unit.sv */
// ----------------------------------------------------------------------------
// xxh64_streaming_hash_unit
// a non-last item is fed into the stripe buffer one byte at a time, with the four lane rounds
// on each full stripe; a last item then converges the lanes once 32 bytes came, adds the length,
// folds leftover 8-byte words, a 4-byte word and single bytes, then runs avalanche and output
// the byte-serial fill and one 32x32 multiplier bound the rate; the front queue holds 4 items
// synchronous active-low reset restores seed 0 and an empty message; a seed write restarts
// ----------------------------------------------------------------------------
module xxh64_streaming_hash_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_bytes,
    input  logic [3:0]  s_byte_count,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value
);

    logic q_valid, q_ready;
    xxh_pkg::item_t q_item;

    xxh_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_bytes(s_data_bytes), .s_byte_count(s_byte_count), .s_last(s_last),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    xxh_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_hash_value(m_hash_value)
    );

endmodule

/* dv/xxh64_streaming_hash_unit_tb.sv */
// ----------------------------------------------------------------------------
// xxh64 streaming hash unit testbench
// drives byte items in bursts, predicts each message digest in the bench and
// compares it with the block's result; seed changes only while the block is idle
// ----------------------------------------------------------------------------
module xxh64_streaming_hash_unit_tb;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        logic        known;
        logic [63:0] digest;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [63:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data_bytes = '0;
    logic [3:0]  s_byte_count = '0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_hash_value;

    logic [63:0] seed_reg;
    logic [63:0] acc [4];
    logic [7:0]  stripe [32];
    int          fill;
    logic [63:0] msg_len;
    logic [63:0] digest_q [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          drain_stall = 1'b0;
    stim_row_t   rows [$];

    always #6 aclk = ~aclk;

    xxh64_streaming_hash_unit u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_bytes(s_data_bytes),
        .s_byte_count(s_byte_count), .s_last(s_last), .m_valid(m_valid),
        .m_ready(m_ready), .m_hash_value(m_hash_value)
    );

    function automatic logic [63:0] rotl(logic [63:0] v, int n);
        return (v << n) | (v >> (64 - n));
    endfunction

    function automatic logic [63:0] lane_mix(logic [63:0] a, logic [63:0] w);
        logic [63:0] t;
        t = a + w * xxh_pkg::P2;
        return rotl(t, 31) * xxh_pkg::P1;
    endfunction

    function automatic logic [63:0] stripe_word(int pos, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v |= 64'(stripe[(pos + i) & 31]) << (8 * i);
        return v;
    endfunction

    task automatic restart_message();
        acc[0] = seed_reg + xxh_pkg::P1 + xxh_pkg::P2;
        acc[1] = seed_reg + xxh_pkg::P2;
        acc[2] = seed_reg;
        acc[3] = seed_reg - xxh_pkg::P1;
        fill = 0;
        msg_len = '0;
    endtask

    function automatic logic [63:0] finish_digest();
        logic [63:0] h;
        int p;
        p = 0;
        if (msg_len >= 64'd32) begin
            h = rotl(acc[0], 1) + rotl(acc[1], 7) + rotl(acc[2], 12) + rotl(acc[3], 18);
            for (int k = 0; k < 4; k++)
                h = (h ^ lane_mix(64'd0, acc[k])) * xxh_pkg::P1 + xxh_pkg::P4;
        end else begin
            h = seed_reg + xxh_pkg::P5;
        end
        h += msg_len;
        while (fill - p >= 8) begin
            h ^= lane_mix(64'd0, stripe_word(p, 8));
            h = rotl(h, 27) * xxh_pkg::P1 + xxh_pkg::P4;
            p += 8;
        end
        if (fill - p >= 4) begin
            h ^= stripe_word(p, 4) * xxh_pkg::P1;
            h = rotl(h, 23) * xxh_pkg::P2 + xxh_pkg::P3;
            p += 4;
        end
        while (p < fill) begin
            h ^= 64'(stripe[p]) * xxh_pkg::P5;
            h = rotl(h, 11) * xxh_pkg::P1;
            p++;
        end
        h ^= h >> 33;
        h *= xxh_pkg::P2;
        h ^= h >> 29;
        h *= xxh_pkg::P3;
        h ^= h >> 32;
        return h;
    endfunction

    // returns 1 and the digest when the item closes a message
    task automatic absorb_item(logic [63:0] data, logic [3:0] count, logic last,
                               output bit done, output logic [63:0] digest);
        int n;
        n = (count > 4'd8) ? 8 : int'(count);
        msg_len += 64'(n);
        for (int i = 0; i < n; i++) begin
            stripe[fill] = data[8*i +: 8];
            fill++;
            if (fill == 32) begin
                for (int k = 0; k < 4; k++) acc[k] = lane_mix(acc[k], stripe_word(8 * k, 8));
                fill = 0;
            end
        end
        done = last;
        digest = '0;
        if (last) begin
            digest = finish_digest();
            restart_message();
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected result hash_value actual %h", m_hash_value);
                errors++;
            end else begin
                if (m_hash_value !== digest_q[0]) begin
                    $error("hash_value expected %h actual %h", digest_q[0], m_hash_value);
                    errors++;
                end
                void'(digest_q.pop_front());
            end
        end
    end

    always @(negedge aclk) begin
        if (drain_stall) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // s_ready only moves at the rising edge, so it is stable at the falling edge
    task automatic send_item(logic [63:0] data, logic [3:0] count, logic last);
        s_data_bytes <= data;
        s_byte_count <= count;
        s_last <= last;
        s_valid <= 1'b1;
        while (!s_ready) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic push_item(logic [63:0] data, logic [3:0] count, logic last,
                             bit known, logic [63:0] want);
        bit done;
        logic [63:0] digest;
        absorb_item(data, count, last, done, digest);
        if (done) begin
            if (known && digest !== want) begin
                $error("hash_value predictor expected %h actual %h", want, digest);
                errors++;
            end
            digest_q.push_back(known ? want : digest);
        end
        send_item(data, count, last);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        drain_stall = 1'b1;
        while (digest_q.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        drain_stall = 1'b0;
    endtask

    task automatic write_seed(logic [63:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        seed_reg = value;
        restart_message();
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_phase(int items);
        int sent;
        int burst;
        int msg_left;
        logic [3:0] cnt;
        sent = 0;
        msg_left = $urandom_range(0, 20);
        while (sent < items) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && sent < items) begin
                cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, 8));
                if ($urandom_range(0, 4) == 0) cnt = 4'd8;
                push_item(rand64(), cnt, msg_left == 0, 1'b0, '0);
                msg_left = (msg_left == 0) ? $urandom_range(0, 24) : msg_left - 1;
                burst--;
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            if ($urandom_range(0, 60) == 0) wait_drained();
        end
        push_item(rand64(), 4'($urandom_range(0, 8)), 1'b1, 1'b0, '0);
    endtask

    initial begin
        stim_row_t r;
        seed_reg = '0;
        restart_message();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty message, seed 0 digest is well known
        rows.push_back('{64'd0, 4'd0, 1'b1, 1'b1, 64'hef46db3751d8e999});
        rows.push_back('{64'hffffffffffffffff, 4'd8, 1'b1, 1'b0, '0});
        rows.push_back('{64'h0, 4'd8, 1'b1, 1'b0, '0});
        rows.push_back('{64'h0123456789abcdef, 4'd15, 1'b1, 1'b0, '0});
        rows.push_back('{64'hdeadbeefcafef00d, 4'd9, 1'b0, 1'b0, '0});
        rows.push_back('{64'h5555aaaa5555aaaa, 4'd3, 1'b0, 1'b0, '0});
        rows.push_back('{64'haaaa5555aaaa5555, 4'd0, 1'b0, 1'b0, '0});
        rows.push_back('{64'h1122334455667788, 4'd4, 1'b1, 1'b0, '0});
        for (int i = 0; i < 5; i++)
            rows.push_back('{{8{8'(8'h11 * (i + 1))}}, 4'd8, i == 4, 1'b0, '0});
        for (int i = 0; i < 5; i++)
            rows.push_back('{64'h8000000000000001 << i, 4'd7, i == 4, 1'b0, '0});
        rows.push_back('{64'h00000000000000ff, 4'd1, 1'b1, 1'b0, '0});
        foreach (rows[i]) begin
            r = rows[i];
            push_item(r.data, r.count, r.last, r.known, r.digest);
        end

        write_seed(64'hffffffffffffffff);
        push_item(64'h0, 4'd0, 1'b1, 1'b0, '0);
        random_phase(250);
        write_seed(64'h0000000000000000);
        random_phase(300);
        write_seed(rand64());
        push_item(64'h0706050403020100, 4'd8, 1'b0, 1'b0, '0);
        write_seed(64'h9e3779b97f4a7c15);
        random_phase(350);
        write_seed(rand64());
        random_phase(350);

        wait_drained();
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

/* xxh64_streaming_hash_unit.f */
hw/rtl/xxh_pkg.sv
hw/rtl/xxh_front.sv
hw/rtl/xxh_core.sv
hw/rtl/xxh64_streaming_hash_unit.sv
dv/xxh64_streaming_hash_unit_tb.sv
